// ===== sv/mqdd_pkg.sv =====
// ----------------------------------------------------------------------------
// mqdd_pkg
// Shared types, constants and helpers for the multi-encoder quadrature
// detent decoder: entry layout, register indexes, port widths, Gray table.
// ----------------------------------------------------------------------------
package mqdd_pkg;

    // Default encoder count and configuration reset values
    localparam int NUM_ENCODERS_DEF = 16;
    localparam logic [3:0]  STEPS_RESET   = 4'd4;
    localparam logic [15:0] HOLDOFF_RESET = 16'd20;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 1'd1;

    // Item kinds carried in tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_INIT   = 1'b1;

    // Stream widths
    localparam int IDX_W       = 4;
    localparam int TIME_W      = 32;
    localparam int ACC_W       = 6;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // Per-encoder state entry
    typedef struct packed {
        logic [1:0]        last_pins;
        logic [1:0]        rest_pins;
        logic              armed;
        logic [ACC_W-1:0]  acc;
        logic [TIME_W-1:0] last_time;
    } enc_entry_t;

    localparam enc_entry_t ENTRY_RESET = '{
        last_pins: 2'd3,
        rest_pins: 2'd3,
        armed:     1'b1,
        acc:       '0,
        last_time: '0
    };

    // Pin code {b, a} to Gray position
    function automatic logic [1:0] gray_pos(input logic [1:0] code);
        logic [1:0] pos;
        case (code)
            2'd0:    pos = 2'd0;
            2'd1:    pos = 2'd1;
            2'd2:    pos = 2'd3;
            2'd3:    pos = 2'd2;
            default: pos = 2'd0;
        endcase
        return pos;
    endfunction

endpackage

// ===== sv/multi_quadrature_detent_decoder_core.sv =====
// An accepted item is captured in stage 1; its event is then loaded into the output register.
// Throughput: one item per cycle while no event waits on a full output register; the per-encoder
// read-modify-write on the state memory forwards the write to a read of the same entry.
// The pipeline holds an item only when it has an event and the output register is full.
// Reset (rst_n, async, active low) clears the pipeline and the per-entry valid bits
// (every encoder reads as idle, armed, rest pins 3) and loads the configuration reset values.
// ----------------------------------------------------------------------------
// multi_quadrature_detent_decoder_core
// Quadrature decoder for several rotary encoders with per-encoder state in
// one synchronous memory; emits clockwise / counter-clockwise detent items.
// ----------------------------------------------------------------------------
module multi_quadrature_detent_decoder_core
    import mqdd_pkg::*;
#(
    parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: [3:0] encoder_index, [4] pin_a, [5] pin_b, [37:6] now_ms, [39:38] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: [0] kind
    input  logic [0:0]             s_tuser,
    // event stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: [3:0] event_encoder, [4] clockwise, [7:5] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    // Configuration registers
    logic [3:0]  steps_reg;
    logic [15:0] holdoff_reg;

    // Stage 1 control and payload
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_kind_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [1:0]        s1_code_reg;
    logic [TIME_W-1:0] s1_now_reg;

    // Memory and read path
    enc_entry_t        entry_mem [NUM_ENCODERS];
    logic [NUM_ENCODERS-1:0] entry_vld_reg;
    enc_entry_t        rd_q_reg;
    logic              rd_vld_reg;
    logic              fwd_hit_reg;
    enc_entry_t        fwd_data_reg;

    // Output register
    logic              m_tvalid_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic              m_cw_reg;

    logic              accept;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              s1_in_range;
    logic              mem_we;
    logic              s1_go;
    logic              s1_emit;
    logic              out_free;
    enc_entry_t        cur_entry;
    enc_entry_t        wr_entry;
    logic              emit_raw;
    logic              dir_cw;

    // Address from the 4-bit index, widened before the range check
    logic [8:0] in_idx_ext;
    logic [8:0] s1_idx_ext;
    assign in_idx_ext  = {5'd0, s_tdata[3:0]};
    assign s1_idx_ext  = {5'd0, s1_idx_reg};
    assign rd_addr     = in_idx_ext[AW-1:0];
    assign wr_addr     = s1_idx_ext[AW-1:0];
    assign s1_in_range = (s1_idx_ext < 9'(NUM_ENCODERS));

    // Handshake and pipeline advance
    assign out_free      = !m_tvalid_reg || m_tready;
    assign s1_emit       = s1_valid_reg && s1_in_range && emit_raw;
    assign s1_go         = s1_valid_reg && (!s1_emit || out_free);
    assign s_tready      = !s1_valid_reg || s1_go;
    assign accept        = s_tvalid && s_tready;
    assign mem_we        = s1_go && s1_in_range;
    assign s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg   <= STEPS_RESET;
            holdoff_reg <= HOLDOFF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEPS:   steps_reg   <= cfg_wdata[3:0];
                REG_HOLDOFF: holdoff_reg <= cfg_wdata[15:0];
                default:     ;
            endcase
        end
    end

    // Stage 1 valid and per-entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            entry_vld_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (mem_we)
                entry_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Capture item and issue the read; forward a same-entry write
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[wr_addr] <= wr_entry;
        if (accept)
        begin
            s1_kind_reg  <= s_tuser[0];
            s1_idx_reg   <= s_tdata[3:0];
            s1_code_reg  <= {s_tdata[5], s_tdata[4]};
            s1_now_reg   <= s_tdata[37:6];
            rd_q_reg     <= entry_mem[rd_addr];
            rd_vld_reg   <= entry_vld_reg[rd_addr];
            fwd_hit_reg  <= mem_we && (wr_addr == rd_addr);
            fwd_data_reg <= wr_entry;
        end
    end

    // Select current entry: forwarded write, stored data or reset value
    always_comb
    begin
        if (fwd_hit_reg)
            cur_entry = fwd_data_reg;
        else if (rd_vld_reg)
            cur_entry = rd_q_reg;
        else
            cur_entry = ENTRY_RESET;
    end

    // Decode step, accumulate, test the detent threshold and holdoff; handle init and re-arm
    logic [1:0]        g_new;
    logic [1:0]        g_old;
    logic signed [3:0] diff;
    logic signed [3:0] delta;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] thr;
    logic              up;
    logic              down;
    logic [TIME_W-1:0] elapsed;
    logic              hold_ok;

    always_comb
    begin
        g_new   = gray_pos(s1_code_reg);
        g_old   = gray_pos(cur_entry.last_pins);
        diff    = $signed({2'b00, g_new}) - $signed({2'b00, g_old});
        if (diff > 4'sd2)
            delta = diff - 4'sd4;
        else if (diff < -4'sd2)
            delta = diff + 4'sd4;
        else
            delta = diff;
        acc_sum = $signed(cur_entry.acc) + $signed({{(ACC_W-4){delta[3]}}, delta});
        thr     = $signed({{(ACC_W-4){1'b0}}, steps_reg});
        up      = (acc_sum >= thr);
        down    = !up && (acc_sum <= -thr);
        elapsed = s1_now_reg - cur_entry.last_time;
        hold_ok = (elapsed >= {16'd0, holdoff_reg});

        wr_entry = cur_entry;
        emit_raw = 1'b0;
        dir_cw   = 1'b0;
        if (s1_kind_reg == KIND_INIT)
        begin
            wr_entry.last_pins = s1_code_reg;
            wr_entry.rest_pins = s1_code_reg;
            wr_entry.armed     = 1'b1;
            wr_entry.acc       = '0;
            wr_entry.last_time = '0;
        end
        else if (s1_code_reg != cur_entry.last_pins)
        begin
            wr_entry.last_pins = s1_code_reg;
            wr_entry.acc       = acc_sum;
            if (cur_entry.armed)
            begin
                if (up || down)
                begin
                    if (hold_ok)
                    begin
                        wr_entry.last_time = s1_now_reg;
                        wr_entry.armed     = 1'b0;
                        emit_raw           = 1'b1;
                        dir_cw             = up;
                    end
                    wr_entry.acc = '0;
                end
            end
            else
            begin
                wr_entry.acc = '0;
            end
            // back at rest: re-arm
            if (s1_code_reg == cur_entry.rest_pins)
            begin
                wr_entry.armed = 1'b1;
                wr_entry.acc   = '0;
            end
        end
    end

    // Output register: load on event, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (s1_go && s1_emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit)
        begin
            m_idx_reg <= s1_idx_reg;
            m_cw_reg  <= dir_cw;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_cw_reg, m_idx_reg};

    // Input is held back only while an event waits on a full output register
    a_ready_only_on_full_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_tvalid_reg && !m_tready)
    ) else $error("input stalled without a blocked event");

    // A new event appears only from an item that sat in stage 1
    a_event_from_stage1: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s1_valid_reg)
    ) else $error("event without a stage 1 item");

    // An emitted event clears the accumulator and leaves the entry disarmed unless the pins sit at rest
    a_event_disarms: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_go && s1_emit) |->
            (wr_entry.acc == '0) &&
            (!wr_entry.armed || (s1_code_reg == cur_entry.rest_pins))
    ) else $error("event left entry armed or accumulator nonzero");

    // A forwarded read only follows a real write in the same cycle
    a_fwd_needs_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        $past(accept) && fwd_hit_reg |-> $past(mem_we)
    ) else $error("forwarding without a memory write");

endmodule

// ===== dv/multi_quadrature_detent_decoder_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_quadrature_detent_decoder_core_tb
// Self-checking bench for the multi-encoder quadrature detent decoder. A
// short table covers rotation in both directions, holdoff with time wrap,
// arming, initialize and a zero step count. Randomized rotation runs with
// noise then follow under several register settings. Every event is checked
// against an in-bench decoder while both stream sides stall at random but in the last phase.
// ----------------------------------------------------------------------------
module multi_quadrature_detent_decoder_core_tb;
    import mqdd_pkg::*;

    localparam int ENCODERS        = 16;
    localparam int SETTLE_CYCLES   = 4;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PHASES          = 6;

    // Gray position of each pin code {b, a}; the table is its own inverse
    localparam logic [1:0] QUAD_POS [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

    // Register settings of the random phases, with the largest step count and both holdoff extremes
    localparam logic [CFG_DATA_W-1:0] PHASE_STEPS [PHASES] = '{1, 15, 4, 2, 9, 3};
    localparam logic [CFG_DATA_W-1:0] PHASE_HOLD  [PHASES] = '{0, 65535, 20, 7, 300, 0};

    // What a table row demands of the decoder, if anything
    typedef enum logic [1:0] {CHK_ANY, CHK_NONE, CHK_CW, CHK_CCW} chk_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  kind;
        logic [IDX_W-1:0]      idx;
        logic [1:0]            code;
        logic [TIME_W-1:0]     now;
        chk_t                  chk;
    } dir_row_t;

    typedef struct packed {
        logic [IDX_W-1:0] enc;
        logic             cw;
    } detent_t;

    function automatic dir_row_t sample_row(input logic [IDX_W-1:0] idx,
                                            input logic [1:0] code,
                                            input logic [TIME_W-1:0] now,
                                            input chk_t chk);
        dir_row_t r;
        r = '0;
        r.kind = KIND_SAMPLE;
        r.idx  = idx;
        r.code = code;
        r.now  = now;
        r.chk  = chk;
        return r;
    endfunction

    function automatic dir_row_t init_row(input logic [IDX_W-1:0] idx,
                                          input logic [1:0] code,
                                          input logic [TIME_W-1:0] now);
        dir_row_t r;
        r = sample_row(idx, code, now, CHK_NONE);
        r.kind = KIND_INIT;
        return r;
    endfunction

    function automatic dir_row_t write_row(input logic [CFG_IDX_W-1:0] sel,
                                           input logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    // Pin codes are written {b, a}
    localparam dir_row_t DIRECTED [27] = '{
        // clockwise detent on encoder 0 at reset settings, then unchanged pins
        sample_row(4'd0,  2'b10, 32'd100, CHK_ANY),
        sample_row(4'd0,  2'b00, 32'd101, CHK_ANY),
        sample_row(4'd0,  2'b01, 32'd102, CHK_ANY),
        sample_row(4'd0,  2'b11, 32'd103, CHK_CW),
        sample_row(4'd0,  2'b11, 32'd104, CHK_NONE),
        // counter-clockwise detent on encoder 15 at the top of the time range
        sample_row(4'd15, 2'b01, 32'hFFFF_FFF0, CHK_ANY),
        sample_row(4'd15, 2'b00, 32'hFFFF_FFF1, CHK_ANY),
        sample_row(4'd15, 2'b10, 32'hFFFF_FFF2, CHK_ANY),
        sample_row(4'd15, 2'b11, 32'hFFFF_FFFF, CHK_CCW),
        // holdoff not passed across the wrap, then passed exactly
        sample_row(4'd15, 2'b01, 32'd2, CHK_ANY),
        sample_row(4'd15, 2'b00, 32'd2, CHK_ANY),
        sample_row(4'd15, 2'b10, 32'd2, CHK_ANY),
        sample_row(4'd15, 2'b11, 32'd2, CHK_NONE),
        sample_row(4'd15, 2'b01, 32'h13, CHK_ANY),
        sample_row(4'd15, 2'b00, 32'h13, CHK_ANY),
        sample_row(4'd15, 2'b10, 32'h13, CHK_ANY),
        sample_row(4'd15, 2'b11, 32'h13, CHK_CCW),
        // odd step count: detent away from rest, disarmed change, rest reached
        write_row(REG_STEPS, 16'd3),
        init_row(4'd3, 2'b01, 32'd200),
        sample_row(4'd3,  2'b11, 32'd200, CHK_ANY),
        sample_row(4'd3,  2'b10, 32'd201, CHK_ANY),
        sample_row(4'd3,  2'b00, 32'd202, CHK_CW),
        sample_row(4'd3,  2'b10, 32'd203, CHK_NONE),
        sample_row(4'd3,  2'b01, 32'd204, CHK_NONE),
        // zero step count: every armed change meets the threshold
        write_row(REG_STEPS, 16'd0),
        sample_row(4'd4,  2'b10, 32'd300, CHK_CW),
        sample_row(4'd5,  2'b01, 32'd300, CHK_CCW)
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    multi_quadrature_detent_decoder_core #(
        .NUM_ENCODERS(ENCODERS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder state mirrored in the bench
    logic [3:0]        cfg_steps;
    logic [15:0]       cfg_holdoff;
    logic [1:0]        enc_last  [ENCODERS];
    logic [1:0]        enc_rest  [ENCODERS];
    bit                enc_armed [ENCODERS];
    int                enc_acc   [ENCODERS];
    logic [TIME_W-1:0] enc_time  [ENCODERS];

    detent_t pending_detents [$];
    bit      last_fire;
    bit      last_cw;
    bit      calm = 1'b0;
    int      err_count = 0;
    int      items_seen = 0;
    int      events_expected = 0;
    int      stall_left = 0;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // Advance one encoder by one item and report any detent it causes
    task automatic decode_sample(input logic kind, input logic [IDX_W-1:0] idx,
                                 input logic [1:0] code, input logic [TIME_W-1:0] now,
                                 output bit fire, output bit cw);
        int delta;
        int thr;
        bit up;
        bit down;
        logic [TIME_W-1:0] elapsed;
        fire = 1'b0;
        cw   = 1'b0;
        thr  = int'(cfg_steps);
        // every 4-bit index names an encoder at this count, so nothing is dropped
        if (kind == KIND_INIT)
        begin
            enc_last[idx]  = code;
            enc_rest[idx]  = code;
            enc_armed[idx] = 1'b1;
            enc_acc[idx]   = 0;
            enc_time[idx]  = '0;
        end
        else if (code != enc_last[idx])
        begin
            delta = int'(QUAD_POS[code]) - int'(QUAD_POS[enc_last[idx]]);
            if (delta > 2)
                delta -= 4;
            else if (delta < -2)
                delta += 4;
            enc_acc[idx] += delta;
            enc_last[idx] = code;
            if (enc_armed[idx])
            begin
                up   = enc_acc[idx] >= thr;
                down = !up && enc_acc[idx] <= -thr;
                if (up || down)
                begin
                    // wrapping time difference against the holdoff
                    elapsed = now - enc_time[idx];
                    if (elapsed >= TIME_W'(cfg_holdoff))
                    begin
                        enc_time[idx]  = now;
                        enc_armed[idx] = 1'b0;
                        fire = 1'b1;
                        cw   = up;
                    end
                    enc_acc[idx] = 0;
                end
            end
            else
                enc_acc[idx] = 0;
            // back at rest: re-arm
            if (code == enc_rest[idx])
            begin
                enc_armed[idx] = 1'b1;
                enc_acc[idx]   = 0;
            end
        end
    endtask

    // Compare events, track register writes and predict each accepted item
    always @(posedge clk)
    begin : monitor
        detent_t want;
        bit fire;
        bit cw;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_detents.size() == 0)
                    flag_mismatch($sformatf("event encoder %0d cw %0b with none expected",
                                            m_tdata[3:0], m_tdata[4]));
                else
                begin
                    want = pending_detents.pop_front();
                    if (m_tdata[3:0] !== want.enc)
                        flag_mismatch($sformatf("event encoder %0d, expected %0d",
                                                m_tdata[3:0], want.enc));
                    if (m_tdata[4] !== want.cw)
                        flag_mismatch($sformatf("encoder %0d direction cw=%0b, expected %0b",
                                                want.enc, m_tdata[4], want.cw));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_STEPS)
                    cfg_steps = cfg_wdata[3:0];
                else if (cfg_index == REG_HOLDOFF)
                    cfg_holdoff = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                decode_sample(s_tuser[0], s_tdata[3:0], s_tdata[5:4], s_tdata[37:6],
                              fire, cw);
                last_fire = fire;
                last_cw   = cw;
                items_seen++;
                if (fire)
                begin
                    pending_detents.push_back('{enc: s_tdata[3:0], cw: cw});
                    events_expected++;
                end
            end
        end
    end

    // Stall the event side in random bursts, never in the calm tail
    always @(negedge clk)
    begin
        if (calm)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Present one item, maybe after a gap, and hold it until accepted
    task automatic offer_item(input logic kind, input logic [IDX_W-1:0] idx,
                              input logic [1:0] code, input logic [TIME_W-1:0] now);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, now, code[1], code[0], idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off the sender until every expected event is out and the pipe is empty
    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (pending_detents.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic              kind;
        logic [IDX_W-1:0]  idx;
        logic [1:0]        code;
        logic [TIME_W-1:0] t_ms;
        int run_enc;
        int run_dir;
        int run_left;
        int step;
        int sent;
        int r;
        int directed_items;
        cfg_steps   = STEPS_RESET;
        cfg_holdoff = HOLDOFF_RESET;
        for (int e = 0; e < ENCODERS; e++)
        begin
            enc_last[e]  = 2'd3;
            enc_rest[e]  = 2'd3;
            enc_armed[e] = 1'b1;
            enc_acc[e]   = 0;
            enc_time[e]  = '0;
        end
        directed_items = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (DIRECTED[i].is_cfg)
            begin
                drain_events();
                write_reg(DIRECTED[i].reg_sel, DIRECTED[i].reg_val);
            end
            else
            begin
                offer_item(DIRECTED[i].kind, DIRECTED[i].idx, DIRECTED[i].code,
                           DIRECTED[i].now);
                directed_items++;
                if (DIRECTED[i].chk != CHK_ANY &&
                    (last_fire != (DIRECTED[i].chk != CHK_NONE) ||
                     (last_fire && last_cw != (DIRECTED[i].chk == CHK_CW))))
                    flag_mismatch($sformatf("directed row %0d: predicted fire=%0b cw=%0b",
                                            i, last_fire, last_cw));
            end
        end
        drain_events();

        // Random phases: rotation runs with random content plus noise
        for (int p = 0; p < PHASES; p++)
        begin
            calm <= (p == PHASES - 1);
            write_reg(REG_STEPS, PHASE_STEPS[p]);
            write_reg(REG_HOLDOFF, PHASE_HOLD[p]);
            t_ms     = $urandom();
            run_left = 0;
            run_enc  = 0;
            run_dir  = 1;
            sent     = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if (run_left == 0)
                begin
                    run_enc  = $urandom_range(0, ENCODERS - 1);
                    run_dir  = $urandom_range(0, 1) ? 1 : 3;
                    run_left = $urandom_range(1, 24);
                end
                kind = KIND_SAMPLE;
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    kind = KIND_INIT;
                    idx  = IDX_W'($urandom_range(0, ENCODERS - 1));
                    code = 2'($urandom_range(0, 3));
                end
                else if (r < 18)
                begin
                    idx  = IDX_W'($urandom_range(0, ENCODERS - 1));
                    code = 2'($urandom_range(0, 3));
                end
                else
                begin
                    // mostly single steps, now and then a jump or a reversal
                    step = run_dir;
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        step = 2;
                    else if (r == 1)
                        step = 4 - run_dir;
                    idx  = IDX_W'(run_enc);
                    code = QUAD_POS[2'(int'(QUAD_POS[enc_last[idx]]) + step)];
                    run_left--;
                end
                // advance time: small steps, some long pauses, rare big jumps
                r = $urandom_range(0, 99);
                if (r < 70)
                    t_ms += $urandom_range(0, 40);
                else if (r < 95)
                    t_ms += $urandom_range(0, 3000);
                else
                    t_ms += $urandom_range(0, 200000);
                if (kind == KIND_INIT || code != enc_last[idx])
                    sent++;
                offer_item(kind, idx, code, t_ms);
                if (!calm && $urandom_range(0, 79) == 0)
                    drain_events();
            end
            drain_events();
        end

        $display("covered %0d items (%0d from the table) over %0d register settings",
                 items_seen, directed_items, PHASES + 3);
        $display("%0d detent events predicted and compared, %0d mismatches",
                 events_expected, err_count);
        if (err_count == 0)
            $display("multi_quadrature_detent_decoder_core_tb: clean");
        else
            $display("multi_quadrature_detent_decoder_core_tb: errors");
        $finish;
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("multi_quadrature_detent_decoder_core_tb: errors");
        $finish;
    end

endmodule
